// ----- src/uxc_pkg.sv -----
// ----------------------------------------------------------------------------
// Unicode transcoder package
// Encoding codes, register indexes and the types shared by the transcoder.
// ----------------------------------------------------------------------------
package uxc_pkg;

  localparam logic [1:0] FMT_UTF8  = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF32 = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam logic [1:0] REG_IN_FORMAT  = 2'd0;
  localparam logic [1:0] REG_OUT_FORMAT = 2'd1;

  localparam int UNIT_W    = 21;
  localparam int MAX_UNITS = 4;

  typedef logic [UNIT_W-1:0] unit_t;

  typedef struct packed {
    unit_t      point;
    logic [1:0] left;
  } uxc_state_t;

  typedef struct packed {
    unit_t [MAX_UNITS-1:0] units;
    logic [2:0]            count;
    logic                  error;
  } uxc_run_t;

endpackage

// ----- src/uxc_step.sv -----
// ----------------------------------------------------------------------------
// Transcoder step
// Decodes one input code unit against the pending sequence and encodes a
// completed code point into its run of output units.
// ----------------------------------------------------------------------------
module uxc_step (
  input  logic [1:0]         in_format,
  input  logic [1:0]         out_format,
  input  logic [31:0]        unit,
  input  uxc_pkg::uxc_state_t state,
  output uxc_pkg::uxc_state_t state_next,
  output uxc_pkg::uxc_run_t   result
);
  import uxc_pkg::*;

  function automatic uxc_run_t encode(input unit_t cp, input logic [1:0] fmt);
    uxc_run_t r;
    unit_t    off;
    begin
      r   = '0;
      off = cp - 21'h10000;
      if (cp > 21'h10FFFF) begin
        r.count = 3'd1;
        r.error = 1'b1;
      end else begin
        case (fmt)
          FMT_UTF8: begin
            if (cp <= 21'h7F) begin
              r.units[0] = cp;
              r.count    = 3'd1;
            end else if (cp <= 21'h7FF) begin
              r.units[0] = {13'b0, 3'b110, cp[10:6]};
              r.units[1] = {13'b0, 2'b10, cp[5:0]};
              r.count    = 3'd2;
            end else if (cp <= 21'hFFFF) begin
              r.units[0] = {13'b0, 4'b1110, cp[15:12]};
              r.units[1] = {13'b0, 2'b10, cp[11:6]};
              r.units[2] = {13'b0, 2'b10, cp[5:0]};
              r.count    = 3'd3;
            end else begin
              r.units[0] = {13'b0, 5'b11110, cp[20:18]};
              r.units[1] = {13'b0, 2'b10, cp[17:12]};
              r.units[2] = {13'b0, 2'b10, cp[11:6]};
              r.units[3] = {13'b0, 2'b10, cp[5:0]};
              r.count    = 3'd4;
            end
          end
          FMT_UTF16: begin
            if (cp < 21'h10000) begin
              r.units[0] = cp;
              r.count    = 3'd1;
            end else begin
              r.units[0] = {5'b0, 6'b110110, off[19:10]};
              r.units[1] = {5'b0, 6'b110111, off[9:0]};
              r.count    = 3'd2;
            end
          end
          default: begin
            r.units[0] = cp;
            r.count    = 3'd1;
          end
        endcase
      end
      return r;
    end
  endfunction

  logic [7:0]  cont;
  unit_t       cont_add;
  unit_t       acc;
  unit_t       pair;
  logic [15:0] u16;

  assign cont = unit[7:0] ^ 8'h80;
  assign u16  = unit[15:0];
  assign acc  = state.point | cont_add;
  assign pair = (state.point | {11'b0, u16[9:0]}) + 21'h10000;

  always_comb begin
    case (state.left)
      2'd1:    cont_add = {13'b0, cont};
      2'd2:    cont_add = {7'b0, cont, 6'b0};
      2'd3:    cont_add = {1'b0, cont, 12'b0};
      default: cont_add = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    result     = '0;
    case (in_format)
      FMT_UTF8: begin
        if (state.left != 2'd0) begin
          if (state.left == 2'd1) begin
            state_next = '0;
            result     = encode(acc, out_format);
          end else begin
            state_next.point = acc;
            state_next.left  = state.left - 2'd1;
          end
        end else if (!unit[7]) begin
          result = encode({13'b0, unit[7:0]}, out_format);
        end else if (unit[7:5] == 3'b110) begin
          state_next.point = {10'b0, unit[4:0], 6'b0};
          state_next.left  = 2'd1;
        end else if (unit[7:4] == 4'b1110) begin
          state_next.point = {5'b0, unit[3:0], 12'b0};
          state_next.left  = 2'd2;
        end else if (unit[7:3] == 5'b11110) begin
          state_next.point = {unit[2:0], 18'b0};
          state_next.left  = 2'd3;
        end else begin
          state_next = '0;
          result     = encode(21'h1FFFFF, out_format);
        end
      end
      FMT_UTF16: begin
        if (state.left != 2'd0) begin
          state_next = '0;
          result     = encode(pair, out_format);
        end else if (u16 < 16'hD800 || u16 >= 16'hE000) begin
          result = encode({5'b0, u16}, out_format);
        end else if (u16 <= 16'hDBFF) begin
          state_next.point = {1'b0, u16[9:0], 10'b0};
          state_next.left  = 2'd1;
        end else begin
          state_next = '0;
          result     = encode(21'h1FFFFF, out_format);
        end
      end
      default: begin
        state_next = '0;
        if (unit > 32'h10FFFF) begin
          result = encode(21'h1FFFFF, out_format);
        end else begin
          result = encode(unit[20:0], out_format);
        end
      end
    endcase
  end

endmodule

// ----- src/unicode_transcoder.sv -----
// ----------------------------------------------------------------------------
// Unicode transcoder
// Converts a stream of UTF-8, UTF-16 or UTF-32 code units into another of
// these encodings, one input code unit per item.
// ----------------------------------------------------------------------------
// The slave stream carries one input code unit per item in s_axis_tdata. The
// master stream returns output code units; m_axis_tlast marks the final unit
// of a code point or an error, and m_axis_tuser flags an error item, whose
// data is zero. The configuration channel selects the input and output
// encodings; it must be written only while the stream is idle, which the
// block itself does not enforce. A write of the input encoding drops any
// partly gathered sequence. An accepted item is held in the input register
// and, once the run buffer is free, loads the run buffer, which presents its
// units in order on the master stream.
// The block takes one item per cycle while each code point yields one unit
// and the receiver takes every unit; a code point that yields k units (k up
// to 4, the run buffer depth) holds the input until its last unit is taken.
// Items that only extend a pending sequence produce nothing and leave the
// run buffer empty. When the receiver stalls, the run buffer holds its unit,
// the input register fills, and s_axis_tready falls. Reset selects UTF-8 in
// and UTF-16 out, and clears both stages and any pending sequence.
// ----------------------------------------------------------------------------
module unicode_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_unit[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_unit[20:0], zero[23:21]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);
  import uxc_pkg::*;

  logic [1:0]            in_format;
  logic [1:0]            out_format;
  logic [1:0]            cfg_fmt;
  uxc_state_t            state;
  uxc_state_t            state_next;
  uxc_run_t              result;
  logic                  in_valid;
  logic [31:0]           in_data;
  logic                  run_valid;
  unit_t [MAX_UNITS-1:0] run_units;
  logic [2:0]            run_count;
  logic                  run_error;
  logic [1:0]            run_idx;
  logic                  run_take;
  logic                  run_free;
  logic                  move;

  uxc_step u_step (
    .in_format  (in_format),
    .out_format (out_format),
    .unit       (in_data),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign cfg_ready     = 1'b1;
  assign cfg_fmt       = (cfg_data == FMT_SPARE) ? FMT_UTF32 : cfg_data;
  assign m_axis_tvalid = run_valid;
  assign m_axis_tdata  = {3'b0, run_units[run_idx]};
  assign m_axis_tlast  = ({1'b0, run_idx} == (run_count - 3'd1));
  assign m_axis_tuser  = run_error;
  assign run_take      = run_valid && m_axis_tready;
  assign run_free      = !run_valid || (m_axis_tready && m_axis_tlast);
  assign move          = in_valid && run_free;
  assign s_axis_tready = !in_valid || run_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_format  <= FMT_UTF8;
      out_format <= FMT_UTF16;
      state      <= '0;
      in_valid   <= 1'b0;
      run_valid  <= 1'b0;
      run_idx    <= 2'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        run_valid <= (result.count != 3'd0);
        run_idx   <= 2'd0;
      end else if (run_take) begin
        if (m_axis_tlast) begin
          run_valid <= 1'b0;
        end else begin
          run_idx <= run_idx + 2'd1;
        end
      end
      if (cfg_valid && cfg_index == REG_IN_FORMAT) begin
        in_format <= cfg_fmt;
        state     <= '0;
      end else if (move) begin
        state <= state_next;
      end
      if (cfg_valid && cfg_index == REG_OUT_FORMAT) begin
        out_format <= cfg_fmt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
    if (move) begin
      run_units <= result.units;
      run_count <= result.count;
      run_error <= result.error;
    end
  end

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run_count != 3'd0 && run_count <= 3'd4))
    else $error("run buffer holds an impossible unit count");

  a_error_item: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 24'd0))
    else $error("error item is not a lone zero unit");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (move && result.error) |=> (state.left == 2'd0))
    else $error("pending sequence survived an error");

  a_format_code: assert property (@(posedge clk) disable iff (rst)
    (in_format != FMT_SPARE && out_format != FMT_SPARE))
    else $error("format register holds the unnormalized code");

endmodule
